### hw/rtl/monitor_link_frame_deframer_defines.svh
// ---------------------------------------------------------------------------
// Monitor link frame deframer: assertion macros
// Shared property wrappers for the checker files.
// ---------------------------------------------------------------------------
`ifndef MONITOR_LINK_FRAME_DEFRAMER_DEFINES_SVH
`define MONITOR_LINK_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MLDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mldf: property violated");

// Next-cycle implication, disabled while in reset.
`define MLDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mldf: property violated");

`endif

### hw/rtl/mldf_pkg.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: package
// Types, codes and helper functions shared by the deframer files.
// ---------------------------------------------------------------------------
package mldf_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 64;

	// Register indexes (paddr[4:3])
	localparam logic [1:0] REG_LEAD  = 2'd0;
	localparam logic [1:0] REG_IDENT = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [7:0]  LEAD_RST  = 8'h68;
	localparam logic [47:0] IDENT_RST = 48'h0;
	localparam logic [15:0] LIMIT_RST = 16'd4096;

	localparam logic [7:0]  END_BYTE       = 8'h16;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd12;
	localparam logic [2:0]  HDR_BYTES      = 3'd7;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_LEN_LIMIT = 2'd1;
	localparam logic [1:0] ST_BAD_END   = 2'd2;
	localparam logic [1:0] ST_BAD_SUM   = 2'd3;

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_CMD     = 7'b0000010,
		PH_LEN_HI  = 7'b0000100,
		PH_LEN_LO  = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_CHECK   = 7'b0100000,
		PH_END     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0]  lead;
		logic [47:0] ident;
		logic [15:0] limit;
	} cfg_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  command_code;
		logic        last_payload;
		logic [1:0]  frame_status;
		logic [16:0] frame_length;
	} res_t;

	// 8-bit sum of the six identifier bytes
	function automatic logic [7:0] ident_sum(input logic [47:0] ident);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 6; i++) begin
			acc = acc + ident[8*i +: 8];
		end
		return acc;
	endfunction

endpackage

### hw/rtl/mldf_rx_if.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: received byte channel
// Valid/ready channel carrying one received byte per request.
// ---------------------------------------------------------------------------
interface mldf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/mldf_res_if.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: result channel
// Valid/ready channel carrying payload bytes and frame end status.
// ---------------------------------------------------------------------------
interface mldf_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  command_code;
	logic        last_payload;
	logic [1:0]  frame_status;
	logic [16:0] frame_length;

	modport source (output valid, output result_kind, output payload_byte,
		output command_code, output last_payload, output frame_status,
		output frame_length, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input command_code, input last_payload, input frame_status,
		input frame_length, output ready);
endinterface

### hw/rtl/monitor_link_frame_deframer.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer
// Byte-serial deframer: hunts the start pattern, passes payload, checks end.
// ---------------------------------------------------------------------------
//   channel   dir  handshake          carries
//   rx        in   valid / ready      rx_byte, one received byte per request
//   res       out  valid / ready      payload byte or frame end status
//   apb       in   psel/penable/pwrite  lead, identifier, length limit
//
// One byte per clock sustained unless res stalls: the frame state machine settles
// each byte in a single pass between the input register and the result register.
// A taken byte is held in the input register, and its result then in the result register.
// A stall on res holds the input register; rx.ready follows res.ready in the
// same cycle once both registers are full.
// Reset (arst_n low) empties both registers, restarts hunting and loads the
// register reset values; no clearing pass follows.
// ---------------------------------------------------------------------------
module monitor_link_frame_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mldf_pkg::ADDR_W-1:0] paddr,
	input  logic [mldf_pkg::DATA_W-1:0] pwdata,
	output logic [mldf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	mldf_rx_if.sink                     rx,
	mldf_res_if.source                  res
);
	import mldf_pkg::*;

	cfg_t       cfg;
	res_t       res_comb;
	logic       res_comb_valid;
	logic       out_free;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;

	// Advance the held byte whenever the result register can take its outcome
	assign step = valid_s1 & out_free;

	mldf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register: one byte deep, refilled in the cycle it drains
	mldf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Frame logic: state advances only on a stepped byte
	mldf_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_comb_valid),
		.res       (res_comb)
	);

	// Result register: drop bytes that give no result, hold the rest for res
	mldf_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (step & res_comb_valid),
		.res_in     (res_comb),
		.out_free   (out_free),
		.res        (res)
	);
endmodule

### hw/rtl/mldf_cfg_regs.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: configuration registers
// APB-style register file for lead byte, identifier and length limit.
// ---------------------------------------------------------------------------
module mldf_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mldf_pkg::ADDR_W-1:0] paddr,
	input  logic [mldf_pkg::DATA_W-1:0] pwdata,
	output logic [mldf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mldf_pkg::cfg_t              cfg
);
	import mldf_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:3];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead  <= LEAD_RST;
			cfg_q.ident <= IDENT_RST;
			cfg_q.limit <= LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEAD:  cfg_q.lead  <= pwdata[7:0];
				REG_IDENT: cfg_q.ident <= pwdata[47:0];
				REG_LIMIT: cfg_q.limit <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LEAD:  prdata = {56'h0, cfg_q.lead};
			REG_IDENT: prdata = {16'h0, cfg_q.ident};
			REG_LIMIT: prdata = {48'h0, cfg_q.limit};
			default:   prdata = '0;
		endcase
	end
endmodule

### hw/rtl/mldf_in_stage.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: input register
// Captures one received byte per cycle, unless advance holds it, ahead of the frame logic.
// ---------------------------------------------------------------------------
module mldf_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	mldf_rx_if.sink    rx,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	// Accept when empty or when the held byte moves on this cycle
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end
endmodule

### hw/rtl/mldf_frame_core.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: frame state machine
// Header hunt, command/length capture, payload pass, checksum and end check.
// ---------------------------------------------------------------------------
module mldf_frame_core (
	input  logic           clk,
	input  logic           arst_n,
	input  mldf_pkg::cfg_t cfg,
	input  logic           step,
	input  logic [7:0]     byte_s1,
	output logic           res_valid,
	output mldf_pkg::res_t res
);
	import mldf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  pos_q, pos_d, pos_inc;
	logic [55:0] win_q, win_d, win_next;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d, len_lo;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d, sum_add;
	logic        good_q, good_d;
	logic [16:0] total;

	assign win_next = {win_q[47:0], byte_s1};
	assign pos_inc  = (pos_q == HDR_BYTES) ? HDR_BYTES : pos_q + 3'd1;
	assign sum_add  = sum_q + byte_s1;
	assign len_lo   = {len_q[15:8], byte_s1};
	// Total length of the frame in hand; the low length byte counts as it arrives
	assign total    = {1'b0, (phase_q == PH_LEN_LO) ? len_lo : len_q} + FRAME_OVERHEAD;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		win_d   = win_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		sum_d   = sum_q;
		good_d  = good_q;

		res_valid        = 1'b0;
		res.result_kind  = KIND_PAYLOAD;
		res.payload_byte = 8'h00;
		res.last_payload = 1'b0;
		res.frame_status = ST_OK;

		case (phase_q)
			PH_HUNT: begin
				win_d = win_next;
				pos_d = pos_inc;
				if (pos_inc == HDR_BYTES && win_next == {cfg.lead, cfg.ident}) begin
					sum_d   = ident_sum(cfg.ident);
					pos_d   = 3'd0;
					win_d   = '0;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				sum_d   = sum_add;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = {byte_s1, 8'h00};
				sum_d   = sum_add;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = len_lo;
				sum_d = sum_add;
				cnt_d = 16'd0;
				if (total >= {1'b0, cfg.limit}) begin
					res_valid        = 1'b1;
					res.result_kind  = KIND_STATUS;
					res.frame_status = ST_LEN_LIMIT;
					phase_d          = PH_HUNT;
					pos_d            = 3'd0;
					win_d            = '0;
				end else if (len_lo == 16'd0) begin
					phase_d = PH_CHECK;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_d            = sum_add;
				cnt_d            = cnt_q + 16'd1;
				res_valid        = 1'b1;
				res.payload_byte = byte_s1;
				if (cnt_d >= len_q) begin
					res.last_payload = 1'b1;
					phase_d          = PH_CHECK;
				end
			end
			PH_CHECK: begin
				good_d  = (~sum_q == byte_s1);
				phase_d = PH_END;
			end
			PH_END: begin
				res_valid       = 1'b1;
				res.result_kind = KIND_STATUS;
				if (byte_s1 != END_BYTE) begin
					res.frame_status = ST_BAD_END;
				end else if (!good_q) begin
					res.frame_status = ST_BAD_SUM;
				end else begin
					res.frame_status = ST_OK;
				end
				phase_d = PH_HUNT;
				pos_d   = 3'd0;
				win_d   = '0;
			end
			default: begin
				phase_d = PH_HUNT;
				pos_d   = 3'd0;
				win_d   = '0;
			end
		endcase

		res.command_code = cmd_q;
		res.frame_length = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= 3'd0;
			win_q   <= '0;
			cmd_q   <= 8'h00;
			len_q   <= 16'd0;
			cnt_q   <= 16'd0;
			sum_q   <= 8'h00;
			good_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			win_q   <= win_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			good_q  <= good_d;
		end
	end
endmodule

### hw/rtl/mldf_out_stage.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module mldf_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_valid,
	input  mldf_pkg::res_t res_in,
	output logic           out_free,
	mldf_res_if.source     res
);
	import mldf_pkg::*;

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load_valid) begin
			res_q <= res_in;
		end
	end

	assign res.valid        = valid_q;
	assign res.result_kind  = res_q.result_kind;
	assign res.payload_byte = res_q.payload_byte;
	assign res.command_code = res_q.command_code;
	assign res.last_payload = res_q.last_payload;
	assign res.frame_status = res_q.frame_status;
	assign res.frame_length = res_q.frame_length;
endmodule

### hw/rtl/mldf_checker.sv
// ---------------------------------------------------------------------------
// Monitor link frame deframer: port checker
// Watches the channels of the top level and flags inconsistent results.
// ---------------------------------------------------------------------------
`include "monitor_link_frame_deframer_defines.svh"

module mldf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_valid,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        result_kind,
	input logic [7:0]  payload_byte,
	input logic        last_payload,
	input logic [1:0]  frame_status,
	input logic [16:0] frame_length
);
	import mldf_pkg::*;

	`MLDF_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(payload_byte) && $stable(frame_status) && $stable(frame_length))
	`MLDF_ASSERT_IMP(a_status_clean, clk, arst_n, res_valid && result_kind == KIND_STATUS, payload_byte == 8'h00 && !last_payload)
	`MLDF_ASSERT_IMP(a_payload_ok, clk, arst_n, res_valid && result_kind == KIND_PAYLOAD, frame_status == ST_OK)
	`MLDF_ASSERT_IMP(a_res_from_byte, clk, arst_n, $rose(res_valid), $past(rx_valid && rx_ready, 2))
endmodule

bind monitor_link_frame_deframer mldf_checker u_mldf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_kind  (res.result_kind),
	.payload_byte (res.payload_byte),
	.last_payload (res.last_payload),
	.frame_status (res.frame_status),
	.frame_length (res.frame_length)
);
